// File: rtl/akf_pkg.sv
// Package for the angle Kalman filter: fixed-point format, arithmetic helpers,
// controller/datapath command and status types. No dependencies.
package akf_pkg;

	localparam int DataWidth = 32;
	localparam int FracBits  = 20;
	localparam int CfgWidth  = 21;
	localparam int BiasWidth = 31;
	localparam int MeasWidth = 29;
	localparam int RateWidth = 31;
	localparam int AddrWidth = 5;

	typedef logic signed [DataWidth-1:0] data_t;

	localparam data_t DataMax = data_t'({1'b0, {(DataWidth-1){1'b1}}});
	localparam data_t DataMin = data_t'({1'b1, {(DataWidth-1){1'b0}}});
	localparam data_t One     = data_t'(64'sd1 <<< FracBits);

	// register byte addresses
	localparam logic [AddrWidth-1:0] AddrStepTime = 5'd0;
	localparam logic [AddrWidth-1:0] AddrAngNoise = 5'd4;
	localparam logic [AddrWidth-1:0] AddrBiasNoise = 5'd8;
	localparam logic [AddrWidth-1:0] AddrMeasNoise = 5'd12;
	localparam logic [AddrWidth-1:0] AddrInitBias = 5'd16;

	localparam logic [CfgWidth-1:0] StepTimeRst  = 21'd1049;
	localparam logic [CfgWidth-1:0] AngNoiseRst  = 21'd1049;
	localparam logic [CfgWidth-1:0] BiasNoiseRst = 21'd3146;
	localparam logic [CfgWidth-1:0] MeasNoiseRst = 21'd31457;

	// datapath operations, one per sequencer step
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,     // latch inputs
		OP_RB,       // t = sat(rate - bias); m = t*dt
		OP_ANG1,     // angle += m
		OP_CSUM,     // t = sat(ba+ab); m = t*dt
		OP_AA1,      // aa = sat(aa + sat(qa - m))
		OP_MBB,      // m = bb*dt
		OP_AB1,      // ab -= m, ba -= m, bb += qb
		OP_DEN,      // den = sat(aa + r); start k0 division
		OP_K0,       // store k0, start k1 division
		OP_K1,       // store k1; innov
		OP_MK0I,     // m = k0*innov
		OP_ANG2,     // angle += m; m = k1*innov
		OP_BIAS2,    // bias += m; m = (1-k0)*aa
		OP_AA2,      // aa = m; m = (1-k0)*ab
		OP_AB2,      // ab = m; m = k1*t0
		OP_BA2,      // ba -= m; m = k1*t1
		OP_BB2,      // bb -= m; output
		OP_DIVWAIT
	} op_t;

	typedef struct packed {
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic den_pos;
	} stat_t;

	function automatic data_t sat_add(input data_t a, input data_t b);
		logic signed [DataWidth:0] s;
		s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
		if (s[DataWidth] != s[DataWidth-1])
			return s[DataWidth] ? DataMin : DataMax;
		return s[DataWidth-1:0];
	endfunction

	function automatic data_t sat_sub(input data_t a, input data_t b);
		logic signed [DataWidth:0] s;
		s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
		if (s[DataWidth] != s[DataWidth-1])
			return s[DataWidth] ? DataMin : DataMax;
		return s[DataWidth-1:0];
	endfunction

endpackage

// File: rtl/angle_kalman_filter.sv
// Angle/gyro-bias Kalman filter top level: APB registers, output register.
// The two gain divisions use the shared divider; both are skipped when the gain
// denominator is not positive. One item at a time, next input taken once the
// sequencer is idle, even while a result waits. Async active-low reset loads
// defaults, angle 0, bias 0, covariance identity.
module angle_kalman_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [akf_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [akf_pkg::MeasWidth-1:0] measured_angle,
	input  logic signed [akf_pkg::RateWidth-1:0] gyro_rate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] filtered_angle,
	output logic signed [31:0] bias_out
);
	import akf_pkg::*;

	logic [CfgWidth-1:0]  dt_q, qa_q, qb_q, r_q;
	logic [BiasWidth-1:0] ib_q;
	logic  wr, bias_load, busy, finish, in_go, out_full;
	cmd_t  cmd;
	stat_t stat;
	data_t ang, bias;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign bias_load = wr && (paddr == AddrInitBias);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= StepTimeRst;
			qa_q <= AngNoiseRst;
			qb_q <= BiasNoiseRst;
			r_q  <= MeasNoiseRst;
			ib_q <= '0;
		end else if (wr) begin
			unique case (paddr)
				AddrStepTime:  dt_q <= pwdata[CfgWidth-1:0];
				AddrAngNoise:  qa_q <= pwdata[CfgWidth-1:0];
				AddrBiasNoise: qb_q <= pwdata[CfgWidth-1:0];
				AddrMeasNoise: r_q  <= pwdata[CfgWidth-1:0];
				AddrInitBias:  ib_q <= pwdata[BiasWidth-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr)
			AddrStepTime:  prdata = 32'(dt_q);
			AddrAngNoise:  prdata = 32'(qa_q);
			AddrBiasNoise: prdata = 32'(qb_q);
			AddrMeasNoise: prdata = 32'(r_q);
			AddrInitBias:  prdata = 32'(signed'(ib_q));
			default:       prdata = '0;
		endcase
	end

	// accept when sequencer idle
	assign in_stall = busy;
	assign in_go    = in_valid && !in_stall;
	assign out_full = out_valid && out_stall;

	akf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .out_full(out_full), .stat(stat),
		.cmd(cmd), .busy(busy), .finish(finish)
	);

	akf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.measured_angle(measured_angle), .gyro_rate(gyro_rate),
		.step_time(dt_q), .angle_noise(qa_q), .bias_noise(qb_q),
		.measure_noise(r_q), .bias_load(bias_load),
		.bias_value(pwdata[BiasWidth-1:0]), .angle_est(ang), .bias_est(bias)
	);

	// hold result until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			filtered_angle <= ang;
			bias_out       <= bias;
		end
	end
endmodule

// File: rtl/akf_mul.sv
// Fixed-point multiplier: registered product, then round and saturate.
// Depends on akf_pkg.
module akf_mul (
	input  logic           clk,
	input  akf_pkg::data_t a,
	input  akf_pkg::data_t b,
	output akf_pkg::data_t p
);
	import akf_pkg::*;

	localparam int MagW = DataWidth + 1;
	localparam int ProdW = 2 * MagW;

	logic [MagW-1:0]  ma, mb;
	logic [ProdW-1:0] prod_q;
	logic             neg_q;
	logic [ProdW-1:0] rnd;
	logic [ProdW-1:0] sh;

	assign ma = a[DataWidth-1] ? MagW'(-{a[DataWidth-1], a}) : MagW'({1'b0, a});
	assign mb = b[DataWidth-1] ? MagW'(-{b[DataWidth-1], b}) : MagW'({1'b0, b});

	// register exact magnitude product
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		neg_q  <= a[DataWidth-1] ^ b[DataWidth-1];
	end

	// round half away from zero, then saturate magnitude
	always_comb begin
		rnd = prod_q + (ProdW'(1) << (FracBits - 1));
		sh  = rnd >> FracBits;
		if (neg_q) begin
			if (sh > ProdW'({1'b1, {(DataWidth-1){1'b0}}}))
				p = DataMin;
			else
				p = data_t'(-sh[DataWidth-1:0]);
		end else begin
			if (sh > ProdW'(DataMax))
				p = DataMax;
			else
				p = data_t'(sh[DataWidth-1:0]);
		end
	end
endmodule

// File: rtl/akf_div.sv
// Restoring divider for gains: q = num * 2^FracBits / den, one bit per cycle.
// Depends on akf_pkg.
module akf_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  akf_pkg::data_t num,
	input  akf_pkg::data_t den,
	output logic           done,
	output akf_pkg::data_t quo
);
	import akf_pkg::*;

	localparam int NumW = DataWidth + FracBits;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0]      dvd_q;
	logic [NumW-1:0]      quo_q;
	logic [DataWidth:0]   rem_q;
	logic [DataWidth-1:0] dsr_q;
	logic                 neg_q;
	logic                 busy_q;
	logic [CntW-1:0]      cnt_q;
	logic [DataWidth:0]   rem_sh;
	logic [DataWidth:0]   num_mag;

	assign num_mag = num[DataWidth-1] ? -{num[DataWidth-1], num} : {1'b0, num};
	assign rem_sh  = {rem_q[DataWidth-1:0], dvd_q[NumW-1]};

	// control: busy flag and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath: shift and subtract (den is positive when used)
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= NumW'({num_mag[DataWidth-1:0], {FracBits{1'b0}}});
			quo_q <= '0;
			rem_q <= '0;
			dsr_q <= den;
			neg_q <= num[DataWidth-1];
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= {1'b0, dsr_q}) begin
				rem_q <= rem_sh - {1'b0, dsr_q};
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	// saturate signed result
	always_comb begin
		if (neg_q) begin
			if (quo_q > NumW'({1'b1, {(DataWidth-1){1'b0}}}))
				quo = DataMin;
			else
				quo = data_t'(-quo_q[DataWidth-1:0]);
		end else begin
			if (quo_q > NumW'(DataMax))
				quo = DataMax;
			else
				quo = data_t'(quo_q[DataWidth-1:0]);
		end
	end
endmodule

// File: rtl/akf_datapath.sv
// Datapath: filter state, covariance, shared multiplier and divider.
// Depends on akf_pkg, akf_mul, akf_div.
module akf_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  akf_pkg::cmd_t                     cmd,
	output akf_pkg::stat_t                    stat,
	input  logic signed [akf_pkg::MeasWidth-1:0] measured_angle,
	input  logic signed [akf_pkg::RateWidth-1:0] gyro_rate,
	input  logic [akf_pkg::CfgWidth-1:0]      step_time,
	input  logic [akf_pkg::CfgWidth-1:0]      angle_noise,
	input  logic [akf_pkg::CfgWidth-1:0]      bias_noise,
	input  logic [akf_pkg::CfgWidth-1:0]      measure_noise,
	input  logic                              bias_load,
	input  logic signed [akf_pkg::BiasWidth-1:0] bias_value,
	output akf_pkg::data_t                    angle_est,
	output akf_pkg::data_t                    bias_est
);
	import akf_pkg::*;

	data_t meas_q, rate_q, ang_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	data_t k0_q, k1_q, inn_q, den_q, t0_q, t1_q;
	data_t ma, mb, mp;
	data_t dt, qa, qb, rr;
	data_t div_num;
	data_t div_den;
	data_t den_nxt;
	logic  div_start;
	logic  div_done;
	data_t div_q;

	assign dt = data_t'(step_time);
	assign qa = data_t'(angle_noise);
	assign qb = data_t'(bias_noise);
	assign rr = data_t'(measure_noise);

	// gain denominator from the predicted covariance
	assign den_nxt = sat_add(aa_q, rr);

	akf_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	akf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_q)
	);

	assign stat.div_done = div_done;
	assign stat.den_pos  = !den_q[DataWidth-1] && (den_q != '0);
	assign angle_est     = ang_q;
	assign bias_est      = bias_q;

	// select multiplier and divider operands for the step
	always_comb begin
		ma = '0;
		mb = '0;
		div_start = 1'b0;
		div_num   = aa_q;
		div_den   = den_q;
		case (cmd.op)
			OP_RB: begin
				ma = sat_sub(rate_q, bias_q); mb = dt;
			end
			OP_CSUM: begin
				ma = sat_add(ba_q, ab_q); mb = dt;
			end
			OP_MBB: begin
				ma = bb_q; mb = dt;
			end
			OP_DEN: begin
				div_start = !den_nxt[DataWidth-1] && (den_nxt != '0);
				div_num = aa_q;
				div_den = den_nxt;
			end
			OP_K0: begin
				div_start = stat.den_pos; div_num = ba_q;
			end
			OP_MK0I: begin
				ma = k0_q; mb = inn_q;
			end
			OP_ANG2: begin
				ma = k1_q; mb = inn_q;
			end
			OP_BIAS2: begin
				ma = sat_sub(One, k0_q); mb = aa_q;
			end
			OP_AA2: begin
				ma = sat_sub(One, k0_q); mb = ab_q;
			end
			OP_AB2: begin
				ma = k1_q; mb = t0_q;
			end
			OP_BA2: begin
				ma = k1_q; mb = t1_q;
			end
			default: ;
		endcase
	end

	// state and covariance updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q <= '0;
			rate_q <= '0;
			ang_q  <= '0;
			bias_q <= '0;
			aa_q   <= One;
			ab_q   <= '0;
			ba_q   <= '0;
			bb_q   <= One;
			k0_q   <= '0;
			k1_q   <= '0;
			inn_q  <= '0;
			den_q  <= '0;
			t0_q   <= '0;
			t1_q   <= '0;
		end else begin
			if (bias_load)
				bias_q <= data_t'(bias_value);
			case (cmd.op)
				OP_LOAD: begin
					meas_q <= data_t'(measured_angle);
					rate_q <= data_t'(gyro_rate);
				end
				OP_ANG1: ang_q <= sat_add(ang_q, mp);
				OP_AA1:  aa_q <= sat_add(aa_q, sat_sub(qa, mp));
				OP_AB1: begin
					ab_q <= sat_sub(ab_q, mp);
					ba_q <= sat_sub(ba_q, mp);
					bb_q <= sat_add(bb_q, qb);
				end
				OP_DEN: begin
					den_q <= den_nxt;
					k0_q  <= '0;
					k1_q  <= '0;
					t0_q  <= aa_q;
					t1_q  <= ab_q;
				end
				OP_K0: begin
					if (stat.den_pos)
						k0_q <= div_q;
				end
				OP_K1: begin
					if (stat.den_pos)
						k1_q <= div_q;
					inn_q <= sat_sub(meas_q, ang_q);
				end
				OP_ANG2:  ang_q <= sat_add(ang_q, mp);
				OP_BIAS2: bias_q <= sat_add(bias_q, mp);
				OP_AA2:   aa_q <= mp;
				OP_AB2:   ab_q <= mp;
				OP_BA2:   ba_q <= sat_sub(ba_q, mp);
				OP_BB2:   bb_q <= sat_sub(bb_q, mp);
				default: ;
			endcase
		end
	end
endmodule

// File: rtl/akf_ctrl.sv
// Sequencer for one filter update: steps the datapath through its operations.
// Depends on akf_pkg.
module akf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_go,
	input  logic           out_full,
	input  akf_pkg::stat_t stat,
	output akf_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           finish
);
	import akf_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RUN  = 8'b0000_0010,
		S_DIV0 = 8'b0000_0100,
		S_DIV1 = 8'b0000_1000,
		S_TAIL = 8'b0001_0000,
		S_HOLD = 8'b0010_0000
	} state_t;

	state_t state_q;
	op_t    op_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd.op = OP_NONE;
		if (state_q == S_IDLE && in_go)
			cmd.op = OP_LOAD;
		else if (state_q == S_RUN || state_q == S_TAIL)
			cmd.op = op_q;
		else if (state_q == S_DIV0 && (stat.div_done || !stat.den_pos))
			cmd.op = OP_K0;
		else if (state_q == S_DIV1 && (stat.div_done || !stat.den_pos))
			cmd.op = OP_K1;
	end

	// advance through the op sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
			finish  <= 1'b0;
		end else begin
			finish <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_go) begin
					state_q <= S_RUN;
					op_q    <= OP_RB;
				end
				S_RUN: begin
					unique case (op_q)
						OP_RB:   op_q <= OP_ANG1;
						OP_ANG1: op_q <= OP_CSUM;
						OP_CSUM: op_q <= OP_AA1;
						OP_AA1:  op_q <= OP_MBB;
						OP_MBB:  op_q <= OP_AB1;
						OP_AB1:  op_q <= OP_DEN;
						default: state_q <= S_DIV0;
					endcase
				end
				S_DIV0: if (stat.div_done || !stat.den_pos) state_q <= S_DIV1;
				S_DIV1: if (stat.div_done || !stat.den_pos) begin
					state_q <= S_TAIL;
					op_q    <= OP_MK0I;
				end
				S_TAIL: begin
					unique case (op_q)
						OP_MK0I:  op_q <= OP_ANG2;
						OP_ANG2:  op_q <= OP_BIAS2;
						OP_BIAS2: op_q <= OP_AA2;
						OP_AA2:   op_q <= OP_AB2;
						OP_AB2:   op_q <= OP_BA2;
						OP_BA2:   op_q <= OP_BB2;
						default: begin
							if (out_full) begin
								state_q <= S_HOLD;
							end else begin
								state_q <= S_IDLE;
								finish  <= 1'b1;
							end
						end
					endcase
				end
				// hold the finished update until the output register frees up
				S_HOLD: if (!out_full) begin
					state_q <= S_IDLE;
					finish  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
